// ----- rtl/mrot_pkg.sv -----
// shared types and codes for the mapped region offset table
// no dependencies; imported by the slot ram and the top level
package mrot_pkg;

	// one region slot as held in the slot memory
	typedef struct packed {
		logic [63:0] backing_off;
		logic [63:0] length;
		logic [63:0] start;
	} slot_t;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	localparam logic [1:0] STAT_DONE     = 2'd0;
	localparam logic [1:0] STAT_HIT      = 2'd1;
	localparam logic [1:0] STAT_MISS     = 2'd2;
	localparam logic [1:0] STAT_NO_TABLE = 2'd3;

endpackage

// ----- rtl/mapped_region_offset_table_unit.sv -----
// Mapped region offset table. Keeps one table of region slots per process id
// (start, length, file offset) in a single slot memory with one read and one
// write port. An insert for a known process writes one slot at the table's
// ring pointer; an insert that claims a new table sweeps all SLOTS_PER_TABLE
// slots of it, one per cycle. Remove and fault lookup read the table one slot
// per cycle through the read port; a lookup stops at its first hit. One item
// is in work at a time; a finished result waits in the output register while
// the next item is taken.
// depends on mrot_pkg and mrot_slot_ram
module mapped_region_offset_table_unit
	import mrot_pkg::*;
#(
	parameter int unsigned PROCESS_TABLES  = 4,
	parameter int unsigned SLOTS_PER_TABLE = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// process_id [31:0], address [95:32], length [159:96], file offset [223:160]
	input  logic [223:0] s_tdata,
	// operation [1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// fault_file_offset [63:0]
	output logic [63:0]  m_tdata,
	// status [1:0]
	output logic [1:0]   m_tuser
);

	localparam int unsigned TW    = (PROCESS_TABLES > 1) ? $clog2(PROCESS_TABLES) : 1;
	localparam int unsigned SW    = (SLOTS_PER_TABLE > 1) ? $clog2(SLOTS_PER_TABLE) : 1;
	localparam int unsigned DEPTH = PROCESS_TABLES * SLOTS_PER_TABLE;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS_PER_TABLE - 1);
	localparam logic [SW-1:0] CLAIM_NEXT = SW'(1 % SLOTS_PER_TABLE);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MATCH,
		ST_FIND,
		ST_DISP,
		ST_CLEAR,
		ST_SCAN,
		ST_OFFS,
		ST_DONE
	} state_t;

	state_t state_q;

	// accepted item
	logic [1:0]  op_q;
	logic [31:0] pid_q;
	logic [63:0] addr_q;
	logic [63:0] len_q;
	logic [63:0] foff_q;

	// table directory
	logic [31:0]   owner_q  [PROCESS_TABLES];
	logic [PROCESS_TABLES-1:0] in_use_q;
	logic [SW-1:0] ring_q   [PROCESS_TABLES];

	logic [PROCESS_TABLES-1:0] hit_q;
	logic [PROCESS_TABLES-1:0] free_q;
	logic [TW-1:0] tidx_q;
	logic          found_q;
	logic          free_any_q;

	logic [SW-1:0] i_q;
	logic          issuing_q;
	logic          chk_s1;
	logic [SW-1:0] chk_idx_s1;
	logic [63:0]   rm_end_q;
	logic [63:0]   hit_start_q;
	logic [63:0]   hit_off_q;
	logic [1:0]    res_status_q;
	logic [63:0]   res_off_q;

	logic          m_tvalid_q;
	logic [63:0]   m_tdata_q;
	logic [1:0]    m_tuser_q;

	// memory ports
	logic          mem_we;
	logic [SW-1:0] wslot;
	slot_t         mem_wdata;
	slot_t         mem_rdata;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	logic [AW-1:0] base;

	slot_t item_slot;
	logic  overlap;
	logic  holds;
	logic [63:0] slot_end;

	logic [PROCESS_TABLES-1:0] hit_iso;
	logic [PROCESS_TABLES-1:0] free_iso;
	logic [TW-1:0] hit_idx;
	logic [TW-1:0] free_idx;

	assign item_slot = '{backing_off: foff_q, length: len_q, start: addr_q};
	assign base      = AW'(AW'(tidx_q) * AW'(SLOTS_PER_TABLE));
	assign mem_waddr = base + AW'(wslot);
	assign mem_raddr = base + AW'(i_q);

	// slot checks on the word read in the previous cycle
	assign slot_end = mem_rdata.start + mem_rdata.length;
	assign overlap  = (mem_rdata.length != 64'd0) && (mem_rdata.start < rm_end_q) &&
	                  (addr_q < slot_end);
	assign holds    = (mem_rdata.length != 64'd0) && (addr_q >= mem_rdata.start) &&
	                  (addr_q < slot_end);

	// lowest set bit of the owner hit and free vectors
	always_comb begin
		hit_iso  = hit_q & (~hit_q + PROCESS_TABLES'(1));
		free_iso = free_q & (~free_q + PROCESS_TABLES'(1));
		hit_idx  = '0;
		free_idx = '0;
		for (int t = 0; t < PROCESS_TABLES; t++) begin
			if (hit_iso[t]) begin
				hit_idx = hit_idx | TW'(t);
			end
			if (free_iso[t]) begin
				free_idx = free_idx | TW'(t);
			end
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		wslot     = '0;
		mem_wdata = '0;
		unique case (state_q)
			ST_DISP: begin
				mem_we    = (op_q == OP_INSERT) && found_q;
				wslot     = ring_q[tidx_q];
				mem_wdata = item_slot;
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				wslot     = i_q;
				mem_wdata = (i_q == '0) ? item_slot : '0;
			end
			ST_SCAN: begin
				mem_we = chk_s1 && (op_q == OP_REMOVE) && overlap;
				wslot  = chk_idx_s1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	mrot_slot_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_slot_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_use_q   <= '0;
			for (int t = 0; t < PROCESS_TABLES; t++) begin
				owner_q[t] <= '0;
				ring_q[t]  <= '0;
			end
			issuing_q  <= 1'b0;
			chk_s1     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tuser;
						pid_q   <= s_tdata[31:0];
						addr_q  <= s_tdata[95:32];
						len_q   <= s_tdata[159:96];
						foff_q  <= s_tdata[223:160];
						state_q <= ST_MATCH;
					end
				end
				ST_MATCH: begin
					for (int t = 0; t < PROCESS_TABLES; t++) begin
						hit_q[t]  <= in_use_q[t] && (owner_q[t] == pid_q);
						free_q[t] <= !in_use_q[t];
					end
					state_q <= ST_FIND;
				end
				ST_FIND: begin
					found_q    <= |hit_q;
					free_any_q <= |free_q;
					tidx_q     <= (|hit_q) ? hit_idx : free_idx;
					state_q    <= ST_DISP;
				end
				ST_DISP: begin
					res_off_q <= '0;
					rm_end_q  <= addr_q + len_q;
					i_q       <= '0;
					case (op_q) inside
						OP_INSERT: begin
							if (found_q) begin
								ring_q[tidx_q] <= (ring_q[tidx_q] == LAST_SLOT) ? '0 :
								                  ring_q[tidx_q] + SW'(1);
								res_status_q   <= STAT_DONE;
								state_q        <= ST_DONE;
							end else if (free_any_q) begin
								in_use_q[tidx_q] <= 1'b1;
								owner_q[tidx_q]  <= pid_q;
								ring_q[tidx_q]   <= CLAIM_NEXT;
								res_status_q     <= STAT_DONE;
								state_q          <= ST_CLEAR;
							end else begin
								res_status_q <= STAT_NO_TABLE;
								state_q      <= ST_DONE;
							end
						end
						OP_REMOVE, OP_LOOKUP: begin
							if (!found_q) begin
								res_status_q <= STAT_NO_TABLE;
								state_q      <= ST_DONE;
							end else begin
								issuing_q <= 1'b1;
								state_q   <= ST_SCAN;
							end
						end
						default: begin
							res_status_q <= STAT_DONE;
							state_q      <= ST_DONE;
						end
					endcase
				end
				ST_CLEAR: begin
					// fresh table: slot 0 gets the item, the rest are emptied
					if (i_q == LAST_SLOT) begin
						state_q <= ST_DONE;
					end else begin
						i_q <= i_q + SW'(1);
					end
				end
				ST_SCAN: begin
					chk_idx_s1 <= i_q;
					if (chk_s1 && (op_q == OP_LOOKUP) && holds) begin
						hit_start_q <= mem_rdata.start;
						hit_off_q   <= mem_rdata.backing_off;
						issuing_q   <= 1'b0;
						chk_s1      <= 1'b0;
						state_q     <= ST_OFFS;
					end else if (chk_s1 && (chk_idx_s1 == LAST_SLOT)) begin
						res_status_q <= (op_q == OP_LOOKUP) ? STAT_MISS : STAT_DONE;
						issuing_q    <= 1'b0;
						chk_s1       <= 1'b0;
						state_q      <= ST_DONE;
					end else begin
						chk_s1 <= issuing_q;
						if (issuing_q) begin
							if (i_q == LAST_SLOT) begin
								issuing_q <= 1'b0;
							end else begin
								i_q <= i_q + SW'(1);
							end
						end
					end
				end
				ST_OFFS: begin
					res_off_q    <= hit_off_q + (addr_q - hit_start_q);
					res_status_q <= STAT_HIT;
					state_q      <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= res_off_q;
						m_tuser_q  <= res_status_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// no slot write while waiting for an item
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mem_we)
		else $error("slot write while idle");

	// an accepted item always starts the owner match
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_MATCH))
		else $error("accepted item did not start owner match");

	// only a lookup hit carries a file offset
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != STAT_HIT)) |-> (m_tdata == 64'd0))
		else $error("offset on a result that is not a hit");

	// ring pointer stays inside its table
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DISP) |-> (ring_q[tidx_q] <= LAST_SLOT))
		else $error("ring pointer beyond last slot");

endmodule

// ----- rtl/mrot_slot_ram.sv -----
// slot memory: one write port, one read port, registered read data
// depends on mrot_pkg for the slot type
module mrot_slot_ram
	import mrot_pkg::*;
#(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  slot_t         wdata,
	input  logic [AW-1:0] raddr,
	output slot_t         rdata
);

	slot_t mem_q [DEPTH];
	slot_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
